### rtl/core/lion_optimizer_update_assert.svh
// Assertion macros used by the checker file of the Lion optimizer block.
// Each macro expands to one labeled concurrent assertion that reports through $error.
`ifndef LION_OPTIMIZER_UPDATE_ASSERT_SVH
`define LION_OPTIMIZER_UPDATE_ASSERT_SVH

// Assertion on an explicit clock and active-low reset.
`define LION_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion on the block clock and reset, which every checker names i_clk and i_rst_n.
`define LION_ASSERT(lbl, prop, msg) `LION_ASSERT_CLK(lbl, i_clk, i_rst_n, prop, msg)

`endif

### rtl/core/lion_pkg.sv
// Shared widths, register codes, reset values and helpers of the Lion optimizer block.
// Used by lion_mstore, lion_optimizer_update and lion_checker; depends on nothing.
`default_nettype none

package lion_pkg;

    localparam int DATA_W     = 32;
    localparam int INDEX_W    = 12;
    localparam int COEF_W     = 16;
    localparam int LR_W       = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Number of entries the index field can address.
    localparam int unsigned INDEX_SPAN       = 4096;
    localparam int unsigned NUM_ELEMENTS_DEF = 4096;

    localparam logic [COEF_W-1:0] BETA_INTERP_RST   = 16'd58982;
    localparam logic [COEF_W-1:0] BETA_MOMENTUM_RST = 16'd64881;
    localparam logic [LR_W-1:0]   LEARN_RATE_RST    = 24'd16777;
    localparam logic [COEF_W-1:0] DECAY_RATE_RST    = 16'd0;

    // One in Q1.16.
    localparam logic [COEF_W:0] Q_ONE16 = 17'h1_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BETA_INTERP   = 3'd0,
        CFG_BETA_MOMENTUM = 3'd1,
        CFG_LEARN_RATE    = 3'd2,
        CFG_DECAY_RATE    = 3'd3
    } t_cfg_idx;

    // Commands to the momentum store for one cycle.
    typedef struct packed {
        logic rd;
        logic wr;
    } t_mem_cmd;

    // Saturate a 34-bit signed value to the signed 32-bit range.
    function automatic logic signed [DATA_W-1:0] sat34(input logic signed [DATA_W+1:0] v);
        logic ovf;
        ovf = (v[DATA_W+1] != v[DATA_W]) || (v[DATA_W] != v[DATA_W-1]);
        if (!ovf) begin
            return v[DATA_W-1:0];
        end else if (v[DATA_W+1]) begin
            return {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            return {1'b0, {(DATA_W-1){1'b1}}};
        end
    endfunction

endpackage

`default_nettype wire

### rtl/core/lion_mstore.sv
// Momentum store of the Lion optimizer block: one synchronous RAM with a registered
// read port, one write port and a zero sweep after reset. Depends on lion_pkg.
`default_nettype none

module lion_mstore import lion_pkg::*; #(
    parameter int unsigned DEPTH = NUM_ELEMENTS_DEF,
    parameter int unsigned AW    = INDEX_W
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_mem_cmd          i_cmd,
    input  wire logic [AW-1:0]     i_rd_addr,
    input  wire logic [AW-1:0]     i_wr_addr,
    input  wire logic [DATA_W-1:0] i_wr_data,
    output logic      [DATA_W-1:0] o_rd_data,
    output logic                   o_busy
);

    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;
    logic [AW-1:0]     r_clr_addr;
    logic              r_clr_busy;

    // The sweep writes one entry per cycle and owns the write port while it runs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == LAST_ADDR) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_cmd.wr) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_clr_busy;

endmodule

`default_nettype wire

### rtl/core/lion_optimizer_update.sv
// Lion optimizer update, one parameter element per item. Items are taken one per cycle
// while o_in_stall is low; each result passes the stage 1, 2 and 3 registers and the
// output register, a four-stage pipeline that decouples the input and output sides and
// holds while the output is stalled. The momentum lives in a single-port-write RAM of
// min(NUM_ELEMENTS, 4096) entries, read on accept and written back as the item leaves
// stage 2; an item whose index equals that of the item in stage 1, or of a stalled item
// in stage 2, waits, since its momentum is then still being computed, while a stage 2
// match that writes back in the accepting cycle is forwarded. After reset the RAM is
// swept to zero, one entry per cycle, and no item is taken until the sweep ends;
// configuration writes are always taken. Depends on lion_pkg and lion_mstore.
`default_nettype none

module lion_optimizer_update import lion_pkg::*; #(
    parameter int unsigned NUM_ELEMENTS = NUM_ELEMENTS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // Input items
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic        [INDEX_W-1:0]    i_elem_index,
    input  wire logic signed [DATA_W-1:0]     i_gradient,
    input  wire logic signed [DATA_W-1:0]     i_weight,
    // Result items
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic             [INDEX_W-1:0]    o_out_index,
    output logic signed      [DATA_W-1:0]     o_new_weight,
    // Register writes
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic        [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic        [CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int unsigned MEM_DEPTH = (NUM_ELEMENTS < INDEX_SPAN) ? NUM_ELEMENTS : INDEX_SPAN;
    localparam int unsigned AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int PROD_W = 50;
    localparam int WF_W   = 58;

    // ---------------------------------------------------------------- registers
    logic [COEF_W-1:0] r_beta_interp;
    logic [COEF_W-1:0] r_beta_momentum;
    logic [LR_W-1:0]   r_learn_rate;
    logic [COEF_W-1:0] r_decay_rate;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beta_interp   <= BETA_INTERP_RST;
            r_beta_momentum <= BETA_MOMENTUM_RST;
            r_learn_rate    <= LEARN_RATE_RST;
            r_decay_rate    <= DECAY_RATE_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_BETA_INTERP:   r_beta_interp   <= i_cfg_wdata[COEF_W-1:0];
                CFG_BETA_MOMENTUM: r_beta_momentum <= i_cfg_wdata[COEF_W-1:0];
                CFG_LEARN_RATE:    r_learn_rate    <= i_cfg_wdata[LR_W-1:0];
                CFG_DECAY_RATE:    r_decay_rate    <= i_cfg_wdata[COEF_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // Decay factor f = 2^24 - round(lr*wd), refreshed every cycle in two steps. It is
    // first used in the second pipeline stage, by which time a prior write has settled.
    logic [LR_W+COEF_W-1:0] r_lrwd;
    logic [LR_W:0]          r_decay_f;
    logic [LR_W+COEF_W-1:0] lrwd_rnd;

    assign lrwd_rnd = r_lrwd + (LR_W+COEF_W)'(32768);

    always_ff @(posedge i_clk) begin
        r_lrwd    <= r_learn_rate * r_decay_rate;
        r_decay_f <= {1'b1, {LR_W{1'b0}}} - {1'b0, lrwd_rnd[LR_W+COEF_W-1:COEF_W]};
    end

    // ---------------------------------------------------------------- flow control
    logic r_s1_valid, r_s2_valid, r_s3_valid, r_out_valid;
    logic en0, en1, en2, en3;
    logic hazard, accept, mem_busy, mem_wr;

    logic        [INDEX_W-1:0] r_s1_idx, r_s2_idx, r_s3_idx, r_out_index;
    logic                      r_s1_in_range, r_s2_in_range;

    assign en3 = !r_out_valid || !i_out_stall;
    assign en2 = !r_s3_valid || en3;
    assign en1 = !r_s2_valid || en2;
    assign en0 = !r_s1_valid || en1;

    // The item one stage ahead has not yet computed its momentum; an item two stages
    // ahead is forwarded when it writes back in the accepting cycle.
    assign hazard = (r_s1_valid && (r_s1_idx == i_elem_index))
                 || (r_s2_valid && !en2 && (r_s2_idx == i_elem_index));

    assign o_in_stall = mem_busy || !en0 || hazard;
    assign accept     = i_in_valid && !o_in_stall;
    assign mem_wr     = en2 && r_s2_valid && r_s2_in_range;

    // ---------------------------------------------------------------- momentum store
    t_mem_cmd           mem_cmd;
    logic [DATA_W-1:0]  mem_rd_data;
    logic signed [DATA_W-1:0] s2_mnew;

    assign mem_cmd.rd = accept;
    assign mem_cmd.wr = mem_wr;

    lion_mstore #(
        .DEPTH (MEM_DEPTH),
        .AW    (AW)
    ) u_mstore (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (mem_cmd),
        .i_rd_addr (i_elem_index[AW-1:0]),
        .i_wr_addr (r_s2_idx[AW-1:0]),
        .i_wr_data (s2_mnew),
        .o_rd_data (mem_rd_data),
        .o_busy    (mem_busy)
    );

    // ---------------------------------------------------------------- stage 1
    logic signed [DATA_W-1:0] r_s1_grad, r_s1_weight, r_s1_fwd_data;
    logic                     r_s1_fwd_hit;
    logic                     in_range;

    assign in_range = ({20'd0, i_elem_index} < 32'(NUM_ELEMENTS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en0) begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_idx      <= i_elem_index;
            r_s1_in_range <= in_range;
            r_s1_grad     <= i_gradient;
            r_s1_weight   <= i_weight;
            r_s1_fwd_hit  <= mem_wr && (r_s2_idx == i_elem_index);
            r_s1_fwd_data <= s2_mnew;
        end
    end

    logic signed [DATA_W-1:0] s1_mom;
    logic signed [COEF_W+1:0] s1_b1, s1_b2, s1_ob1, s1_ob2;

    always_comb begin
        if (!r_s1_in_range) begin
            s1_mom = '0;
        end else if (r_s1_fwd_hit) begin
            s1_mom = r_s1_fwd_data;
        end else begin
            s1_mom = mem_rd_data;
        end
    end

    assign s1_b1  = $signed({2'b00, r_beta_interp});
    assign s1_b2  = $signed({2'b00, r_beta_momentum});
    assign s1_ob1 = $signed({1'b0, Q_ONE16 - {1'b0, r_beta_interp}});
    assign s1_ob2 = $signed({1'b0, Q_ONE16 - {1'b0, r_beta_momentum}});

    // ---------------------------------------------------------------- stage 2
    logic signed [PROD_W-1:0] r_s2_b1m, r_s2_b1g, r_s2_b2m, r_s2_b2g;
    logic signed [DATA_W-1:0] r_s2_weight;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (en1) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1 && r_s1_valid) begin
            r_s2_idx      <= r_s1_idx;
            r_s2_in_range <= r_s1_in_range;
            r_s2_weight   <= r_s1_weight;
            r_s2_b1m      <= s1_b1 * s1_mom;
            r_s2_b1g      <= s1_ob1 * r_s1_grad;
            r_s2_b2m      <= s1_b2 * s1_mom;
            r_s2_b2g      <= s1_ob2 * r_s1_grad;
        end
    end

    logic signed [PROD_W-1:0] s2_interp, s2_msum;
    logic signed [WF_W-1:0]   s2_wf;
    logic                     s2_pos, s2_neg;

    assign s2_interp = r_s2_b1m + r_s2_b1g;
    assign s2_msum   = r_s2_b2m + r_s2_b2g + PROD_W'(32768);
    assign s2_mnew   = sat34(s2_msum[PROD_W-1:16]);
    assign s2_pos    = !s2_interp[PROD_W-1] && (s2_interp != '0);
    assign s2_neg    = s2_interp[PROD_W-1];
    assign s2_wf     = r_s2_weight * $signed({1'b0, r_decay_f});

    // ---------------------------------------------------------------- stage 3
    logic signed [WF_W-1:0] r_s3_wf;
    logic                   r_s3_pos, r_s3_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (en2) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2 && r_s2_valid) begin
            r_s3_idx <= r_s2_idx;
            r_s3_wf  <= s2_wf;
            r_s3_pos <= s2_pos;
            r_s3_neg <= s2_neg;
        end
    end

    logic signed [WF_W-1:0]   s3_step, s3_acc;
    logic signed [DATA_W-1:0] s3_new_weight;

    assign s3_step = $signed({{(WF_W-LR_W-16){1'b0}}, r_learn_rate, 16'd0});

    always_comb begin
        s3_acc = r_s3_wf + WF_W'(1 << 23);
        if (r_s3_pos) begin
            s3_acc = s3_acc - s3_step;
        end else if (r_s3_neg) begin
            s3_acc = s3_acc + s3_step;
        end
    end

    assign s3_new_weight = sat34(s3_acc[WF_W-1:24]);

    // ---------------------------------------------------------------- output register
    logic signed [DATA_W-1:0] r_out_weight;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en3) begin
            r_out_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3 && r_s3_valid) begin
            r_out_index  <= r_s3_idx;
            r_out_weight <= s3_new_weight;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_index  = r_out_index;
    assign o_new_weight = r_out_weight;

endmodule

`default_nettype wire

### rtl/core/lion_checker.sv
// Port-level checks of the Lion optimizer block, bound to the top level.
// Depends on lion_pkg and the macros in lion_optimizer_update_assert.svh.
`default_nettype none
`include "lion_optimizer_update_assert.svh"

module lion_checker import lion_pkg::*; (
    input wire logic                     i_clk,
    input wire logic                     i_rst_n,
    input wire logic                     i_in_valid,
    input wire logic                     i_in_stall,
    input wire logic [INDEX_W-1:0]       i_elem_index,
    input wire logic                     i_out_valid,
    input wire logic                     i_out_stall,
    input wire logic [INDEX_W-1:0]       i_out_index,
    input wire logic [DATA_W-1:0]        i_new_weight
);

    // A waiting result keeps its valid and its payload.
    `LION_ASSERT(a_out_hold, i_out_valid && i_out_stall |=> i_out_valid, "result dropped while stalled")
    `LION_ASSERT(a_out_stable, i_out_valid && i_out_stall |=> $stable(i_out_index) && $stable(i_new_weight), "stalled result changed")

    // The zero sweep blocks items right after reset, and no result is pending then.
    `LION_ASSERT(a_reset_exit, $rose(i_rst_n) |-> i_in_stall && !i_out_valid, "items taken during momentum sweep")

    // A fresh result rises once its item has passed the stage 1, 2 and 3 registers and the
    // output register; the check looks back to the edge that took that item.
    `LION_ASSERT(a_latency, $rose(i_out_valid) |-> $past(i_in_valid && !i_in_stall, 4), "result without a matching item")

    // The same index is never taken in two consecutive cycles.
    `LION_ASSERT(a_repeat_gap, (i_in_valid && !i_in_stall) |=> !(i_in_valid && !i_in_stall && (i_elem_index == $past(i_elem_index))), "repeated index not held back")

endmodule

bind lion_optimizer_update lion_checker u_lion_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .i_in_stall   (o_in_stall),
    .i_elem_index (i_elem_index),
    .i_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .i_out_index  (o_out_index),
    .i_new_weight (o_new_weight)
);

`default_nettype wire
